// ----- rtl/ghacc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GHASH accumulator package
// Shared widths, types and register indexes of the GHASH accumulator.
// ----------------------------------------------------------------------------
package ghacc_pkg;

  localparam int unsigned HalfW  = 64;
  localparam int unsigned GfBits = 2 * HalfW;
  localparam int unsigned CfgIdxW = 1;

  typedef logic [HalfW-1:0]  half_t;
  typedef logic [GfBits-1:0] gf_elem_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_t;

  // One configuration write, as seen by the key register bank.
  typedef struct packed {
    logic       we;
    cfg_idx_t   index;
    half_t      data;
  } cfg_wr_t;

endpackage

// ----- rtl/ghacc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GHASH accumulator channels
// Valid/ready channels for input blocks and for result tags.
// ----------------------------------------------------------------------------
interface ghacc_in_if;
  import ghacc_pkg::*;

  logic  valid;
  logic  ready;
  half_t block_high;
  half_t block_low;
  logic  restart;

  modport source (output valid, block_high, block_low, restart, input ready);
  modport sink   (input valid, block_high, block_low, restart, output ready);
endinterface

interface ghacc_out_if;
  import ghacc_pkg::*;

  logic  valid;
  logic  ready;
  half_t tag_high;
  half_t tag_low;

  modport source (output valid, tag_high, tag_low, input ready);
  modport sink   (input valid, tag_high, tag_low, output ready);
endinterface

// ----- rtl/ghacc_keyreg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GHASH key register bank
// Holds the hash key H, written one 64-bit half at a time.
// ----------------------------------------------------------------------------
module ghacc_keyreg (
  input  logic                clk,
  input  logic                rst_n,
  input  ghacc_pkg::cfg_wr_t  cfg_wr,
  output ghacc_pkg::gf_elem_t key
);
  import ghacc_pkg::*;

  half_t key_high_r, key_high_nxt;
  half_t key_low_r,  key_low_nxt;

  always_comb begin
    key_high_nxt = key_high_r;
    key_low_nxt  = key_low_r;
    if (cfg_wr.we) begin
      case (cfg_wr.index)
        CFG_KEY_HIGH: key_high_nxt = cfg_wr.data;
        CFG_KEY_LOW:  key_low_nxt  = cfg_wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else begin
      key_high_r <= key_high_nxt;
      key_low_r  <= key_low_nxt;
    end
  end

  assign key = {key_high_r, key_low_r};

endmodule

// ----- rtl/ghacc_gfmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^128) multiplier
// Combinational GCM field multiply: carry-less product, then reduction.
// ----------------------------------------------------------------------------
module ghacc_gfmul (
  input  ghacc_pkg::gf_elem_t a_word,
  input  ghacc_pkg::gf_elem_t b_word,
  output ghacc_pkg::gf_elem_t p_word
);
  import ghacc_pkg::*;

  // GCM stores the x^0 coefficient in the most significant bit of the word,
  // so operands are bit-reversed into ordinary polynomial order.
  function automatic gf_elem_t bit_rev(input gf_elem_t w);
    gf_elem_t r;
    for (int i = 0; i < GfBits; i++) begin
      r[i] = w[GfBits-1-i];
    end
    return r;
  endfunction

  gf_elem_t                  a_poly;
  gf_elem_t                  b_poly;
  logic [2*GfBits-2:0]       prod;
  logic [GfBits-2:0]         hi;
  logic [GfBits+5:0]         fold1;
  logic [5:0]                ovf;
  logic [12:0]               fold2;
  gf_elem_t                  r_poly;

  assign a_poly = bit_rev(a_word);
  assign b_poly = bit_rev(b_word);

  // Partial products are independent; synthesis balances the XOR tree.
  always_comb begin
    prod = '0;
    for (int i = 0; i < GfBits; i++) begin
      if (b_poly[i]) begin
        prod = prod ^ ({{(GfBits-1){1'b0}}, a_poly} << i);
      end
    end
  end

  // x^128 = x^7 + x^2 + x + 1; the top six bits fold over once more.
  assign hi    = prod[2*GfBits-2:GfBits];
  assign fold1 = {7'b0, hi} ^ {6'b0, hi, 1'b0} ^ {5'b0, hi, 2'b0} ^ {hi, 7'b0};
  assign ovf   = fold1[GfBits+5:GfBits];
  assign fold2 = {7'b0, ovf} ^ {6'b0, ovf, 1'b0} ^ {5'b0, ovf, 2'b0} ^ {ovf, 7'b0};

  assign r_poly = prod[GfBits-1:0] ^ fold1[GfBits-1:0]
                ^ {{(GfBits-13){1'b0}}, fold2};
  assign p_word = bit_rev(r_poly);

endmodule

// ----- rtl/ghash_accumulator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GHASH accumulator
// Folds 128-bit blocks into a running GHASH value, one block per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Path: an accepted word is registered in the input stage, where it waits until
//   the result register is free; its tag is then registered in the accumulator.
// Throughput: one block per cycle unless the output stalls; the accumulator
//   feedback loop through the combinational GF(2^128) multiplier sets that rate.
// Reset: synchronous, active low; clears the key, the accumulator and both
//   stage valid flags. No clearing pass is needed.
module ghash_accumulator_top (
  input  logic                       clk,
  input  logic                       rst_n,
  ghacc_in_if.sink                   in_chan,
  ghacc_out_if.source                out_chan,
  input  logic                       cfg_we,
  input  logic [ghacc_pkg::CfgIdxW-1:0] cfg_index,
  input  ghacc_pkg::half_t           cfg_data
);
  import ghacc_pkg::*;

  // Configuration writes are packed into one struct for the key bank. The
  // index is cast to the register enum; both codes of the one-bit index
  // are defined registers.
  cfg_wr_t  cfg_wr;
  gf_elem_t key;

  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_idx_t'(cfg_index);
  assign cfg_wr.data  = cfg_data;

  ghacc_keyreg u_keyreg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .key    (key)
  );

  // Input stage: holds one accepted word until the result register is free.
  logic     s1_v_r,      s1_v_nxt;
  gf_elem_t s1_block_r;
  logic     s1_restart_r;

  // Result stage: the accumulator itself doubles as the output register,
  // since the tag is always the freshly updated accumulator.
  logic     out_v_r,     out_v_nxt;
  gf_elem_t acc_r,       acc_nxt;

  logic     out_free;
  logic     advance;
  logic     in_take;
  gf_elem_t mul_in;
  gf_elem_t mul_out;

  // The result register can take a new value when it is empty or when its
  // current word leaves this cycle. The input stage then hands its word on,
  // and can itself be refilled in the same cycle.
  assign out_free = !out_v_r || out_chan.ready;
  assign advance  = s1_v_r && out_free;
  assign in_chan.ready = !s1_v_r || advance;
  assign in_take  = in_chan.valid && in_chan.ready;

  // A restart block starts a fresh hash, so the old accumulator is dropped.
  assign mul_in = s1_restart_r ? s1_block_r : (acc_r ^ s1_block_r);

  ghacc_gfmul u_gfmul (
    .a_word (mul_in),
    .b_word (key),
    .p_word (mul_out)
  );

  always_comb begin
    s1_v_nxt  = in_take || (s1_v_r && !advance);
    out_v_nxt = advance || (out_v_r && !out_chan.ready);
    acc_nxt   = advance ? mul_out : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      acc_r   <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Payload of the input stage needs no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_block_r   <= {in_chan.block_high, in_chan.block_low};
      s1_restart_r <= in_chan.restart;
    end
  end

  assign out_chan.valid    = out_v_r;
  assign out_chan.tag_high = acc_r[GfBits-1:HalfW];
  assign out_chan.tag_low  = acc_r[HalfW-1:0];

`ifndef SYNTH
  // A tag waiting on a stalled output must not be overwritten.
  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_chan.ready) |=> $stable(acc_r))
    else $error("accumulator changed while its tag was stalled");

  // Every word that leaves the input stage produces a valid tag.
  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("input stage advanced without producing a tag");

  // With both stages full and the output stalled, no new word may enter.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("word accepted while pipeline was full and stalled");

  // An empty input stage always takes a word.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_chan.ready)
    else $error("input stage empty but not ready");
`endif

endmodule
